// File: sv/lsu_pkg.sv
`default_nettype none

package lsu_pkg;

    // Register codes as they appear in opcode bits 5..3 and 2..0
    typedef enum logic [2:0] {
        REG_B   = 3'd0,
        REG_C   = 3'd1,
        REG_D   = 3'd2,
        REG_E   = 3'd3,
        REG_H   = 3'd4,
        REG_L   = 3'd5,
        REG_MEM = 3'd6,
        REG_A   = 3'd7
    } reg_code_t;

    localparam logic [7:0] OP_HALT      = 8'h76;
    localparam logic [7:0] OP_LD_B_N    = 8'h06;
    localparam logic [7:0] OP_LD_C_N    = 8'h0E;
    localparam logic [7:0] OP_LD_D_N    = 8'h16;
    localparam logic [7:0] OP_LD_E_N    = 8'h1E;
    localparam logic [7:0] OP_LD_H_N    = 8'h26;
    localparam logic [7:0] OP_LD_L_N    = 8'h2E;
    localparam logic [7:0] OP_LD_A_N    = 8'h3E;
    localparam logic [7:0] OP_LD_DE_NN  = 8'h11;
    localparam logic [7:0] OP_LD_HL_NN  = 8'h21;
    localparam logic [7:0] OP_LD_SP_NN  = 8'h31;
    localparam logic [7:0] OP_LD_HLI_A  = 8'h22;
    localparam logic [7:0] OP_LD_HLD_A  = 8'h32;
    localparam logic [7:0] OP_LD_BC_A   = 8'h02;
    localparam logic [7:0] OP_LD_DE_A   = 8'h12;
    localparam logic [7:0] OP_LD_NN_A   = 8'hEA;
    localparam logic [7:0] OP_LD_A_DE   = 8'h1A;
    localparam logic [7:0] OP_LDH_N_A   = 8'hE0;
    localparam logic [7:0] OP_LDH_C_A   = 8'hE2;

    localparam logic [7:0] HIGH_PAGE    = 8'hFF;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
    } regs_t;

    // Decoded instruction: memory request plus register state after it,
    // with the destination of a memory load still to be filled in
    typedef struct packed {
        logic      handled;
        logic      mem_rd;
        logic      mem_wr;
        logic [15:0] mem_addr;
        logic [7:0]  mem_wdata;
        regs_t     regs;
        reg_code_t load_dst;
    } exec_t;

    function automatic logic [7:0] get_reg(regs_t r, reg_code_t code);
        logic [7:0] v;
        case (code)
            REG_B:   v = r.b;
            REG_C:   v = r.c;
            REG_D:   v = r.d;
            REG_E:   v = r.e;
            REG_H:   v = r.h;
            REG_L:   v = r.l;
            default: v = r.a;
        endcase
        return v;
    endfunction

    function automatic regs_t put_reg(regs_t r, reg_code_t code, logic [7:0] v);
        regs_t o;
        o = r;
        case (code)
            REG_B:   o.b = v;
            REG_C:   o.c = v;
            REG_D:   o.d = v;
            REG_E:   o.e = v;
            REG_H:   o.h = v;
            REG_L:   o.l = v;
            default: o.a = v;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

// File: sv/lsu_ram.sv
`default_nettype none

module lsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/lsu_exec.sv
`default_nettype none

module lsu_exec (
    input  wire logic [7:0]    command,
    input  wire logic [7:0]    imm_low,
    input  wire logic [7:0]    imm_high,
    input  wire lsu_pkg::regs_t cur,
    output lsu_pkg::exec_t     ex
);

    logic [15:0]          hl;
    lsu_pkg::reg_code_t   dst;
    lsu_pkg::reg_code_t   src;
    logic [7:0]           src_val;

    assign hl      = {cur.h, cur.l};
    assign dst     = lsu_pkg::reg_code_t'(command[5:3]);
    assign src     = lsu_pkg::reg_code_t'(command[2:0]);
    assign src_val = lsu_pkg::get_reg(cur, src);

    always_comb begin
        ex           = '0;
        ex.handled   = 1'b1;
        ex.regs      = cur;
        ex.load_dst  = lsu_pkg::REG_A;
        if (command[7:6] == 2'b01 && command != lsu_pkg::OP_HALT) begin
            if (src == lsu_pkg::REG_MEM) begin
                ex.mem_rd   = 1'b1;
                ex.mem_addr = hl;
                ex.load_dst = dst;
            end else if (dst == lsu_pkg::REG_MEM) begin
                ex.mem_wr    = 1'b1;
                ex.mem_addr  = hl;
                ex.mem_wdata = src_val;
            end else begin
                ex.regs = lsu_pkg::put_reg(cur, dst, src_val);
            end
        end else begin
            case (command)
                lsu_pkg::OP_LD_B_N, lsu_pkg::OP_LD_C_N, lsu_pkg::OP_LD_D_N,
                lsu_pkg::OP_LD_E_N, lsu_pkg::OP_LD_H_N, lsu_pkg::OP_LD_L_N,
                lsu_pkg::OP_LD_A_N: begin
                    ex.regs = lsu_pkg::put_reg(cur, dst, imm_low);
                end
                lsu_pkg::OP_LD_DE_NN: begin
                    ex.regs.d = imm_high;
                    ex.regs.e = imm_low;
                end
                lsu_pkg::OP_LD_HL_NN: begin
                    ex.regs.h = imm_high;
                    ex.regs.l = imm_low;
                end
                lsu_pkg::OP_LD_SP_NN: begin
                    ex.regs.sp = {imm_high, imm_low};
                end
                lsu_pkg::OP_LD_HLI_A: begin
                    ex.mem_wr              = 1'b1;
                    ex.mem_addr            = hl;
                    ex.mem_wdata           = cur.a;
                    {ex.regs.h, ex.regs.l} = hl + 16'd1;
                end
                lsu_pkg::OP_LD_HLD_A: begin
                    ex.mem_wr              = 1'b1;
                    ex.mem_addr            = hl;
                    ex.mem_wdata           = cur.a;
                    {ex.regs.h, ex.regs.l} = hl - 16'd1;
                end
                lsu_pkg::OP_LD_BC_A: begin
                    ex.mem_wr    = 1'b1;
                    ex.mem_addr  = {cur.b, cur.c};
                    ex.mem_wdata = cur.a;
                end
                lsu_pkg::OP_LD_DE_A: begin
                    ex.mem_wr    = 1'b1;
                    ex.mem_addr  = {cur.d, cur.e};
                    ex.mem_wdata = cur.a;
                end
                lsu_pkg::OP_LD_NN_A: begin
                    ex.mem_wr    = 1'b1;
                    ex.mem_addr  = {imm_high, imm_low};
                    ex.mem_wdata = cur.a;
                end
                lsu_pkg::OP_LD_A_DE: begin
                    ex.mem_rd   = 1'b1;
                    ex.mem_addr = {cur.d, cur.e};
                    ex.load_dst = lsu_pkg::REG_A;
                end
                lsu_pkg::OP_LDH_N_A: begin
                    ex.mem_wr    = 1'b1;
                    ex.mem_addr  = {lsu_pkg::HIGH_PAGE, imm_low};
                    ex.mem_wdata = cur.a;
                end
                lsu_pkg::OP_LDH_C_A: begin
                    ex.mem_wr    = 1'b1;
                    ex.mem_addr  = {lsu_pkg::HIGH_PAGE, cur.c};
                    ex.mem_wdata = cur.a;
                end
                default: begin
                    ex.handled = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/lr35902_load_store_unit.sv
`default_nettype none

// Load/store unit for the LR35902 8-bit CPU: executes one load instruction per
// input word (opcode plus two immediate bytes) against registers A, B, C, D, E,
// H, L, SP and a 2^ADDR_BITS byte data memory, and returns one result word per
// instruction with the memory access made and the register values after it.
// After reset the data memory is swept to zero, one byte per cycle, and
// s_tready stays low until the sweep is done. From then on the unit accepts a
// word every cycle unless the read and output stages are full and m_tready is
// low. Each instruction makes its single memory access (read or write, never
// both) on the one RAM port in the cycle it is accepted, and a load's data
// leaves the RAM in the cycle after, where it is forwarded straight into the
// register view of the next instruction. Results pass the read stage register
// and then the output register. Memory addresses at or above 2^ADDR_BITS alias
// onto the lower bytes; mem_addr still shows the full 16-bit address.
module lr35902_load_store_unit #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // command[7:0], imm_low[15:8], imm_high[23:16]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // mem_addr[15:0], mem_byte[23:16], a_now[31:24],
                                        // bc_now[47:32], de_now[63:48], hl_now[79:64],
                                        // sp_now[95:80]
    output logic [1:0]       m_tuser    // handled[0], mem_written[1]
);

    localparam int MemDepth = 2 ** ADDR_BITS;

    // Memory-read stage: carries everything but the load data
    typedef struct packed {
        logic               handled;
        logic               mem_wr;
        logic               mem_rd;
        logic [15:0]        mem_addr;
        logic [7:0]         mem_wdata;
        lsu_pkg::regs_t     regs;
        lsu_pkg::reg_code_t load_dst;
    } rd_stage_t;

    typedef struct packed {
        logic        mem_written;
        logic        handled;
        logic [15:0] sp;
        logic [15:0] hl;
        logic [15:0] de;
        logic [15:0] bc;
        logic [7:0]  a;
        logic [7:0]  mem_byte;
        logic [15:0] mem_addr;
    } out_word_t;

    // Architectural registers, with a load's destination still pending on RAM data
    lsu_pkg::regs_t     regs_reg, regs_next;
    logic               pend_reg, pend_next;
    lsu_pkg::reg_code_t pend_dst_reg;
    lsu_pkg::regs_t     cur_regs;

    rd_stage_t          rd_reg;
    logic               rd_valid_reg;
    out_word_t          out_reg, out_next;
    logic               out_valid_reg;

    logic                 clr_busy_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    lsu_pkg::exec_t       ex;
    logic                 accept;
    logic                 rd_advance;
    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [7:0]           ram_wdata;
    logic [7:0]           ram_rdata;
    lsu_pkg::regs_t       rd_regs_done;

    // Forward the RAM data of the previous load into the current register view
    assign cur_regs = pend_reg ? lsu_pkg::put_reg(regs_reg, pend_dst_reg, ram_rdata)
                               : regs_reg;

    lsu_exec u_exec (
        .command  (s_tdata[7:0]),
        .imm_low  (s_tdata[15:8]),
        .imm_high (s_tdata[23:16]),
        .cur      (cur_regs),
        .ex       (ex)
    );

    // Advance the read stage when the output register is free or being drained
    assign rd_advance = !out_valid_reg || m_tready;
    assign s_tready   = !clr_busy_reg && (!rd_valid_reg || rd_advance);
    assign accept     = s_tvalid && s_tready;

    // Single RAM port: clearing sweep first, then one access per instruction
    always_comb begin
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_re    = 1'b0;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = accept && ex.mem_wr;
            ram_re    = accept && ex.mem_rd;
            ram_addr  = ex.mem_addr[ADDR_BITS-1:0];
            ram_wdata = ex.mem_wdata;
        end
    end

    lsu_ram #(
        .WIDTH (8),
        .DEPTH (MemDepth)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Fold any pending load every cycle; a new load leaves its destination pending
    assign regs_next = accept ? ex.regs : cur_regs;
    assign pend_next = accept && ex.mem_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg     <= '0;
            pend_reg     <= 1'b0;
            pend_dst_reg <= lsu_pkg::REG_A;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            regs_reg <= regs_next;
            pend_reg <= pend_next;
            if (accept) begin
                pend_dst_reg <= ex.load_dst;
            end
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
                if (&clr_addr_reg) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Read stage: hold the decoded instruction while RAM data comes back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (accept) begin
            rd_valid_reg <= 1'b1;
        end else if (rd_advance) begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg.handled   <= ex.handled;
            rd_reg.mem_wr    <= ex.mem_wr;
            rd_reg.mem_rd    <= ex.mem_rd;
            rd_reg.mem_addr  <= ex.mem_addr;
            rd_reg.mem_wdata <= ex.mem_wdata;
            rd_reg.regs      <= ex.regs;
            rd_reg.load_dst  <= ex.load_dst;
        end
    end

    // Merge the load data; the RAM read register holds while this stage stalls
    assign rd_regs_done = rd_reg.mem_rd
                        ? lsu_pkg::put_reg(rd_reg.regs, rd_reg.load_dst, ram_rdata)
                        : rd_reg.regs;

    always_comb begin
        out_next.mem_written = rd_reg.mem_wr;
        out_next.handled     = rd_reg.handled;
        out_next.sp          = rd_regs_done.sp;
        out_next.hl          = {rd_regs_done.h, rd_regs_done.l};
        out_next.de          = {rd_regs_done.d, rd_regs_done.e};
        out_next.bc          = {rd_regs_done.b, rd_regs_done.c};
        out_next.a           = rd_regs_done.a;
        out_next.mem_byte    = rd_reg.mem_rd ? ram_rdata : rd_reg.mem_wdata;
        out_next.mem_addr    = rd_reg.mem_addr;
    end

    // Output register: decouples the result word from the next accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rd_valid_reg && rd_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && rd_advance) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.sp, out_reg.hl, out_reg.de, out_reg.bc,
                       out_reg.a, out_reg.mem_byte, out_reg.mem_addr};
    assign m_tuser  = {out_reg.mem_written, out_reg.handled};

endmodule

`default_nettype wire

// File: sim/lr35902_load_store_unit_tb.sv
module lr35902_load_store_unit_tb;

    localparam int MEM_ADDR_BITS = 16;
    localparam logic [15:0] MEM_MASK = 16'((32'd1 << MEM_ADDR_BITS) - 1);
    // covers the post-reset memory sweep plus generous margin
    localparam int STALL_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 140;

    typedef struct {
        logic        handled;
        logic        mem_written;
        logic [15:0] mem_addr;
        logic [7:0]  mem_byte;
        logic [7:0]  a_now;
        logic [15:0] bc_now;
        logic [15:0] de_now;
        logic [15:0] hl_now;
        logic [15:0] sp_now;
    } ld_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // command[7:0], imm_low[15:8], imm_high[23:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // mem_addr, mem_byte, a_now, bc_now, de_now, hl_now, sp_now
    logic [1:0]  m_tuser;   // handled[0], mem_written[1]

    // shadow CPU state
    lsu_pkg::regs_t cpu_regs;
    logic [7:0]     shadow_mem [0:65535];

    ld_result_t pending_results[$];
    int         fail_count;
    int         idle_cycles = 0;
    int         send_idle_pct;
    int         recv_idle_pct;

    lr35902_load_store_unit #(
        .ADDR_BITS(MEM_ADDR_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] read_reg(lsu_pkg::reg_code_t code);
        case (code)
            lsu_pkg::REG_B:   return cpu_regs.b;
            lsu_pkg::REG_C:   return cpu_regs.c;
            lsu_pkg::REG_D:   return cpu_regs.d;
            lsu_pkg::REG_E:   return cpu_regs.e;
            lsu_pkg::REG_H:   return cpu_regs.h;
            lsu_pkg::REG_L:   return cpu_regs.l;
            default:          return cpu_regs.a;
        endcase
    endfunction

    function automatic void write_reg(lsu_pkg::reg_code_t code, logic [7:0] v);
        case (code)
            lsu_pkg::REG_B:   cpu_regs.b = v;
            lsu_pkg::REG_C:   cpu_regs.c = v;
            lsu_pkg::REG_D:   cpu_regs.d = v;
            lsu_pkg::REG_E:   cpu_regs.e = v;
            lsu_pkg::REG_H:   cpu_regs.h = v;
            lsu_pkg::REG_L:   cpu_regs.l = v;
            default:          cpu_regs.a = v;
        endcase
    endfunction

    // Execute one instruction on the shadow state and return what the unit should report
    function automatic ld_result_t execute_load(logic [7:0] cmd, logic [7:0] n, logic [7:0] nh);
        ld_result_t         r;
        logic [15:0]        hl;
        logic [15:0]        addr;
        logic [7:0]         v;
        logic               access;
        logic               wr;
        lsu_pkg::reg_code_t dst;
        lsu_pkg::reg_code_t src;
        hl = {cpu_regs.h, cpu_regs.l};
        addr = '0;
        v = '0;
        access = 1'b0;
        wr = 1'b0;
        r.handled = 1'b1;
        if (cmd[7:6] == 2'b01 && cmd != lsu_pkg::OP_HALT) begin
            dst = lsu_pkg::reg_code_t'(cmd[5:3]);
            src = lsu_pkg::reg_code_t'(cmd[2:0]);
            if (src == lsu_pkg::REG_MEM) begin
                addr = hl;
                v = shadow_mem[addr & MEM_MASK];
                access = 1'b1;
            end else begin
                v = read_reg(src);
            end
            if (dst == lsu_pkg::REG_MEM) begin
                addr = hl;
                access = 1'b1;
                wr = 1'b1;
            end else begin
                write_reg(dst, v);
            end
        end else begin
            case (cmd)
                lsu_pkg::OP_LD_B_N, lsu_pkg::OP_LD_C_N, lsu_pkg::OP_LD_D_N,
                lsu_pkg::OP_LD_E_N, lsu_pkg::OP_LD_H_N, lsu_pkg::OP_LD_L_N,
                lsu_pkg::OP_LD_A_N: write_reg(lsu_pkg::reg_code_t'(cmd[5:3]), n);
                lsu_pkg::OP_LD_DE_NN: begin
                    cpu_regs.d = nh;
                    cpu_regs.e = n;
                end
                lsu_pkg::OP_LD_HL_NN: begin
                    cpu_regs.h = nh;
                    cpu_regs.l = n;
                end
                lsu_pkg::OP_LD_SP_NN: cpu_regs.sp = {nh, n};
                lsu_pkg::OP_LD_HLI_A, lsu_pkg::OP_LD_HLD_A: begin
                    addr = hl;
                    v = cpu_regs.a;
                    access = 1'b1;
                    wr = 1'b1;
                    {cpu_regs.h, cpu_regs.l} = (cmd == lsu_pkg::OP_LD_HLI_A)
                                             ? hl + 16'd1 : hl - 16'd1;
                end
                lsu_pkg::OP_LD_BC_A, lsu_pkg::OP_LD_DE_A, lsu_pkg::OP_LD_NN_A,
                lsu_pkg::OP_LDH_N_A, lsu_pkg::OP_LDH_C_A: begin
                    case (cmd)
                        lsu_pkg::OP_LD_BC_A: addr = {cpu_regs.b, cpu_regs.c};
                        lsu_pkg::OP_LD_DE_A: addr = {cpu_regs.d, cpu_regs.e};
                        lsu_pkg::OP_LD_NN_A: addr = {nh, n};
                        lsu_pkg::OP_LDH_N_A: addr = {lsu_pkg::HIGH_PAGE, n};
                        default:             addr = {lsu_pkg::HIGH_PAGE, cpu_regs.c};
                    endcase
                    v = cpu_regs.a;
                    access = 1'b1;
                    wr = 1'b1;
                end
                lsu_pkg::OP_LD_A_DE: begin
                    addr = {cpu_regs.d, cpu_regs.e};
                    v = shadow_mem[addr & MEM_MASK];
                    cpu_regs.a = v;
                    access = 1'b1;
                end
                default: r.handled = 1'b0;
            endcase
        end
        if (wr)
            shadow_mem[addr & MEM_MASK] = v;
        r.mem_written = wr;
        r.mem_addr    = access ? addr : 16'h0000;
        r.mem_byte    = access ? v : 8'h00;
        r.a_now       = cpu_regs.a;
        r.bc_now      = {cpu_regs.b, cpu_regs.c};
        r.de_now      = {cpu_regs.d, cpu_regs.e};
        r.hl_now      = {cpu_regs.h, cpu_regs.l};
        r.sp_now      = cpu_regs.sp;
        return r;
    endfunction

    // Offer one instruction word; hold it until accepted, then record its expected result
    task automatic send_instruction(logic [7:0] cmd, logic [7:0] n, logic [7:0] nh);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {nh, n, cmd};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(execute_load(cmd, n, nh));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: drop tready at random, re-rolled every cycle
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, logic [15:0] expected, logic [15:0] actual);
        if (expected !== actual) begin
            $error("%s: expected %h, got %h", name, expected, actual);
            fail_count++;
        end
    endtask

    // Compare every accepted result word against the oldest expectation
    always @(posedge aclk) begin
        ld_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no instruction outstanding");
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("handled",     16'(exp_r.handled),     16'(m_tuser[0]));
                check_field("mem_written", 16'(exp_r.mem_written), 16'(m_tuser[1]));
                check_field("mem_addr",    exp_r.mem_addr,         m_tdata[15:0]);
                check_field("mem_byte",    16'(exp_r.mem_byte),    16'(m_tdata[23:16]));
                check_field("a_now",       16'(exp_r.a_now),       16'(m_tdata[31:24]));
                check_field("bc_now",      exp_r.bc_now,           m_tdata[47:32]);
                check_field("de_now",      exp_r.de_now,           m_tdata[63:48]);
                check_field("hl_now",      exp_r.hl_now,           m_tdata[79:64]);
                check_field("sp_now",      exp_r.sp_now,           m_tdata[95:80]);
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Addresses biased toward a few small windows so loads see earlier stores
    function automatic logic [15:0] pick_addr();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(65535));
            1:       return {lsu_pkg::HIGH_PAGE, 8'($urandom_range(15))};
            2:       return 16'($urandom_range(15));
            default: return 16'hFFFF - 16'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [7:0] pick_imm_op();
        case ($urandom_range(6))
            0:       return lsu_pkg::OP_LD_B_N;
            1:       return lsu_pkg::OP_LD_C_N;
            2:       return lsu_pkg::OP_LD_D_N;
            3:       return lsu_pkg::OP_LD_E_N;
            4:       return lsu_pkg::OP_LD_H_N;
            5:       return lsu_pkg::OP_LD_L_N;
            default: return lsu_pkg::OP_LD_A_N;
        endcase
    endfunction

    function automatic logic [7:0] pick_access_op();
        case ($urandom_range(7))
            0:       return lsu_pkg::OP_LD_HLI_A;
            1:       return lsu_pkg::OP_LD_HLD_A;
            2:       return lsu_pkg::OP_LD_BC_A;
            3:       return lsu_pkg::OP_LD_DE_A;
            4:       return lsu_pkg::OP_LD_NN_A;
            5:       return lsu_pkg::OP_LDH_N_A;
            6:       return lsu_pkg::OP_LDH_C_A;
            default: return lsu_pkg::OP_LD_A_DE;
        endcase
    endfunction

    task automatic send_random_instruction();
        logic [15:0] addr;
        logic [7:0]  cmd;
        int          pick;
        addr = pick_addr();
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: any opcode, including unhandled ones and HALT
            send_instruction(8'($urandom_range(255)), 8'($urandom), 8'($urandom));
        end else if (pick < 25) begin
            case ($urandom_range(4))
                0:       cmd = lsu_pkg::OP_LD_HL_NN;
                1:       cmd = lsu_pkg::OP_LD_DE_NN;
                2:       cmd = lsu_pkg::OP_LD_SP_NN;
                3:       cmd = lsu_pkg::OP_LD_B_N;
                default: cmd = lsu_pkg::OP_LD_C_N;
            endcase
            // B takes the high byte and C the low byte of the chosen address
            if (cmd == lsu_pkg::OP_LD_B_N)
                send_instruction(cmd, addr[15:8], 8'($urandom));
            else
                send_instruction(cmd, addr[7:0], addr[15:8]);
        end else if (pick < 45) begin
            cmd = {2'b01, 3'($urandom_range(7)), 3'($urandom_range(7))};
            send_instruction(cmd, 8'($urandom), 8'($urandom));
        end else if (pick < 60) begin
            send_instruction(pick_imm_op(), 8'($urandom), 8'($urandom));
        end else begin
            send_instruction(pick_access_op(), addr[7:0], addr[15:8]);
        end
    endtask

    task automatic test_immediate_loads();
        send_instruction(lsu_pkg::OP_LD_A_N,   8'hFF, 8'h00);
        send_instruction(lsu_pkg::OP_LD_B_N,   8'h00, 8'hFF);
        send_instruction(lsu_pkg::OP_LD_C_N,   8'hFF, 8'hFF);
        send_instruction(lsu_pkg::OP_LD_D_N,   8'h80, 8'h00);
        send_instruction(lsu_pkg::OP_LD_E_N,   8'h01, 8'h00);
        send_instruction(lsu_pkg::OP_LD_H_N,   8'hFF, 8'h00);
        send_instruction(lsu_pkg::OP_LD_L_N,   8'hFF, 8'h00);
        send_instruction(lsu_pkg::OP_LD_DE_NN, 8'hFF, 8'hFF);
        send_instruction(lsu_pkg::OP_LD_SP_NN, 8'hFF, 8'hFF);
        send_instruction(lsu_pkg::OP_LD_SP_NN, 8'h00, 8'h00);
    endtask

    task automatic test_memory_access();
        // increment past the top of the address space wraps HL to zero
        send_instruction(lsu_pkg::OP_LD_HLI_A, 8'h00, 8'h00);
        // decrement below zero wraps HL back to the top
        send_instruction(lsu_pkg::OP_LD_HLD_A, 8'h00, 8'h00);
        send_instruction(lsu_pkg::OP_LD_BC_A,  8'h00, 8'h00);
        send_instruction(lsu_pkg::OP_LD_DE_A,  8'h00, 8'h00);
        // high address byte comes from the second immediate
        send_instruction(lsu_pkg::OP_LD_NN_A,  8'h12, 8'h34);
        send_instruction(lsu_pkg::OP_LDH_N_A,  8'hFF, 8'h00);
        send_instruction(lsu_pkg::OP_LDH_C_A,  8'h00, 8'h00);
        send_instruction(lsu_pkg::OP_LD_A_DE,  8'h00, 8'h00);
    endtask

    task automatic test_register_moves();
        send_instruction(lsu_pkg::OP_LD_HL_NN, 8'h12, 8'h34);
        send_instruction({2'b01, lsu_pkg::REG_MEM, lsu_pkg::REG_B}, 8'h00, 8'h00);
        send_instruction({2'b01, lsu_pkg::REG_A, lsu_pkg::REG_MEM}, 8'h00, 8'h00);
        send_instruction({2'b01, lsu_pkg::REG_H, lsu_pkg::REG_MEM}, 8'h00, 8'h00);
        send_instruction({2'b01, lsu_pkg::REG_B, lsu_pkg::REG_A}, 8'h00, 8'h00);
    endtask

    task automatic test_unhandled_opcodes();
        send_instruction(lsu_pkg::OP_HALT, 8'hFF, 8'hFF);
        send_instruction(8'h00,            8'h00, 8'h00);
        send_instruction(8'h01,            8'hAA, 8'h55);
        send_instruction(8'hFF,            8'hFF, 8'hFF);
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (RANDOM_PER_PHASE)
            send_random_instruction();
        drain_results();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        fail_count    = 0;
        send_idle_pct = 26;
        recv_idle_pct = 69;
        cpu_regs      = '0;
        for (int i = 0; i < 65536; i++)
            shadow_mem[i] = 8'h00;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_immediate_loads();
        test_memory_access();
        test_register_moves();
        test_unhandled_opcodes();
        test_random_phase(26, 69);
        test_random_phase(69, 26);
        test_random_phase(0, 0);

        // let any late word surface before judging
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/lsu_pkg.sv
sv/lsu_ram.sv
sv/lsu_exec.sv
sv/lr35902_load_store_unit.sv
sim/lr35902_load_store_unit_tb.sv
